FILE: src/bmh_pkg.sv
`default_nettype none

package bmh_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 8;
    localparam int STATUS_W = 2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam status_t ST_OK = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: src/bmh_ram.sv
`default_nettype none

module bmh_ram #(
    parameter int DEPTH = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire bmh_pkg::key_t     wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output bmh_pkg::key_t          rdata
);
    import bmh_pkg::*;

    key_t mem [DEPTH];
    key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/binary_max_heap_priority_queue.sv
`default_nettype none

// Bounded max-heap priority queue of signed 32-bit keys. An input transfer with
// s_tuser = 0 inserts s_tdata; s_tuser = 1 extracts the maximum. Each command gives
// exactly one output transfer with the key (maximum on extract, -1 on an empty
// extract, 0 on insert), a status (ok, full, empty) and the entry count afterwards.
// The heap lives in a single-port-read, single-port-write RAM with registered read
// data, and one signed comparator walks it one level at a time, so the block
// handles one command at a time. An insert sifts up level by level and an extract
// sifts down level by level; a refused insert or an empty extract goes straight to
// the result, with no walk.
// Each level of a walk needs one RAM read per node that it compares.
module binary_max_heap_priority_queue #(
    parameter int HEAP_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // key_in[31:0]
    input  wire logic [0:0]  s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // key_out[31:0], occupancy[39:32]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import bmh_pkg::*;

    localparam int ADDR_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W = ADDR_W + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UP = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_EX_ROOT = 4'd3;
    localparam logic [3:0] S_EX_LAST = 4'd4;
    localparam logic [3:0] S_DN_L = 4'd5;
    localparam logic [3:0] S_DN_R = 4'd6;
    localparam logic [3:0] S_DN_CMP = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    key_t key_reg, key_next;
    key_t best_val_reg, best_val_next;
    logic best_left_reg, best_left_next;
    key_t res_key_reg, res_key_next;
    status_t res_status_reg, res_status_next;

    logic m_valid_reg, m_valid_next;
    key_t m_key_reg, m_key_next;
    status_t m_status_reg, m_status_next;
    logic [OCC_W-1:0] m_occ_reg, m_occ_next;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    key_t ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    key_t ram_rdata;

    logic accept;
    logic [ADDR_W-1:0] pos_m1;
    logic [ADDR_W-1:0] parent;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
    logic [IDX_W-1:0] count_ext;
    logic [CNT_W+OCC_W-1:0] occ_ext;
    key_t cmp_lhs;
    key_t cmp_rhs;
    logic cmp_gt;
    logic right_gt;

    bmh_ram #(
        .DEPTH (HEAP_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;

    assign pos_m1 = pos_reg - 1'b1;
    assign parent = pos_m1 >> 1;
    assign left_idx = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign count_ext = IDX_W'(count_reg);
    assign occ_ext = {{OCC_W{1'b0}}, count_reg};

    // One comparator serves both walks: the held key against its parent going up,
    // and a child against the best candidate so far going down.
    always_comb
    begin
        cmp_lhs = ram_rdata;
        cmp_rhs = key_reg;
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_lhs = key_reg;
                cmp_rhs = ram_rdata;
            end
            S_DN_CMP:
            begin
                cmp_rhs = best_val_reg;
            end
            default:
            begin
                cmp_lhs = ram_rdata;
            end
        endcase
    end

    assign cmp_gt = $signed(cmp_lhs) > $signed(cmp_rhs);
    assign right_gt = (right_idx < count_ext) && cmp_gt;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        key_next = key_reg;
        best_val_next = best_val_reg;
        best_left_next = best_left_reg;
        res_key_next = res_key_reg;
        res_status_next = res_status_reg;
        m_valid_next = m_valid_reg;
        m_key_next = m_key_reg;
        m_status_next = m_status_reg;
        m_occ_next = m_occ_reg;
        ram_we = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = key_reg;
        ram_raddr = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_key_next = '0;
                    res_status_next = ST_OK;
                    if (s_tuser[0] == CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(HEAP_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // The new key is held in a register while a hole
                            // climbs from the first free slot.
                            key_next = s_tdata;
                            pos_next = count_reg[ADDR_W-1:0];
                            count_next = count_reg + 1'b1;
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_key_next = '1;
                            res_status_next = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_raddr = '0;
                            count_next = count_reg - 1'b1;
                            state_next = S_EX_ROOT;
                        end
                    end
                end
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    // The parent moves down into the hole.
                    ram_wdata = ram_rdata;
                    pos_next = parent;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EX_ROOT:
            begin
                res_key_next = ram_rdata;
                ram_raddr = count_reg[ADDR_W-1:0];
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                key_next = ram_rdata;
                pos_next = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (left_idx >= count_ext)
                begin
                    ram_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr = left_idx[ADDR_W-1:0];
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                // The right child read may fall past the heap; its data is then
                // ignored in the next cycle.
                ram_raddr = right_idx[ADDR_W-1:0];
                best_left_next = cmp_gt;
                best_val_next = cmp_gt ? ram_rdata : key_reg;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (right_gt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next = right_idx[ADDR_W-1:0];
                    state_next = S_DN_L;
                end
                else if (best_left_reg)
                begin
                    ram_wdata = best_val_reg;
                    pos_next = left_idx[ADDR_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_key_next = res_key_reg;
                    m_status_next = res_status_reg;
                    m_occ_next = occ_ext[OCC_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        best_val_reg <= best_val_next;
        best_left_reg <= best_left_next;
        res_key_reg <= res_key_next;
        res_status_reg <= res_status_next;
        m_key_reg <= m_key_next;
        m_status_reg <= m_status_next;
        m_occ_reg <= m_occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {m_occ_reg, m_key_reg};
    assign m_tuser = m_status_reg;

endmodule

`default_nettype wire

FILE: bench/heap_result_checker.sv
`default_nettype none

module heap_result_checker
    import bmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // key_in[31:0]
    input  wire logic [0:0]  s_tuser,   // command[0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // key_out[31:0], occupancy[39:32]
    input  wire logic [1:0]  m_tuser,   // status[1:0]
    output int               fail_count,
    output int               outstanding
);

    typedef struct packed {
        key_t           key;
        status_t        status;
        logic [OCC_W-1:0] occupancy;
    } heap_answer_t;

    key_t         heap_keys [HEAP_DEPTH];
    int           heap_size;
    heap_answer_t pending_answers [$];
    int           mismatches;

    initial begin
        fail_count = 0;
        outstanding = 0;
        mismatches = 0;
        heap_size = 0;
    end

    // Applies one command to the local copy of the heap and returns what the
    // block should answer.
    function automatic heap_answer_t predict_answer(logic cmd, key_t key);
        heap_answer_t answer;
        int           pos;
        int           parent;
        int           best;
        int           left;
        int           right;
        key_t         tmp;
        answer.key = '0;
        answer.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (heap_size >= HEAP_DEPTH) begin
                answer.status = ST_FULL;
            end
            else begin
                pos = heap_size;
                heap_keys[pos] = key;
                heap_size++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!(heap_keys[pos] > heap_keys[parent]))
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[parent];
                    heap_keys[parent] = tmp;
                    pos = parent;
                end
            end
        end
        else begin
            if (heap_size == 0) begin
                answer.status = ST_EMPTY;
                answer.key = '1;
            end
            else begin
                answer.key = heap_keys[0];
                heap_keys[0] = heap_keys[heap_size - 1];
                heap_size--;
                pos = 0;
                while (pos < heap_size) begin
                    best = pos;
                    left = 2 * pos + 1;
                    right = 2 * pos + 2;
                    // A tie keeps the left child, and a tie with the parent stops the walk.
                    if (left < heap_size && heap_keys[left] > heap_keys[best])
                        best = left;
                    if (right < heap_size && heap_keys[right] > heap_keys[best])
                        best = right;
                    if (best == pos)
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        answer.occupancy = heap_size[OCC_W-1:0];
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        heap_answer_t want;
        heap_answer_t got;
        if (!rst_n) begin
            heap_size = 0;
            pending_answers.delete();
            outstanding <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.key = m_tdata[31:0];
                got.occupancy = m_tdata[39:32];
                got.status = m_tuser;
                if (pending_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer: key %0d status %0d occupancy %0d",
                                 got.key, got.status, got.occupancy);
                end
                else begin
                    want = pending_answers.pop_front();
                    if (got.key !== want.key || got.status !== want.status ||
                        got.occupancy !== want.occupancy) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Result mismatch: key %0d/%0d status %0d/%0d ",
                                      "occupancy %0d/%0d (expected/actual)"},
                                     want.key, got.key, want.status, got.status,
                                     want.occupancy, got.occupancy);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_answers.push_back(predict_answer(s_tuser[0], key_t'(s_tdata)));
            outstanding <= pending_answers.size();
            fail_count <= mismatches;
        end
    end

endmodule

`default_nettype wire

FILE: bench/binary_max_heap_priority_queue_tb.sv
`default_nettype none

module binary_max_heap_priority_queue_tb;
    import bmh_pkg::*;

    localparam int DEPTH = 128;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // key_in[31:0]
    logic [0:0]  s_tuser = '0;   // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // key_out[31:0], occupancy[39:32]
    logic [1:0]  m_tuser;        // status[1:0]

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int ready_mode = 0;
    int ready_phase_left = 0;
    int burst_left = 0;

    binary_max_heap_priority_queue #(
        .HEAP_DEPTH(DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    heap_result_checker #(
        .HEAP_DEPTH(DEPTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver switches between free flow, light back-pressure and long stalls.
    always @(negedge clk) begin
        if (ready_phase_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_phase_left = $urandom_range(50, 300);
        end
        else begin
            ready_phase_left--;
        end
        case (ready_mode)
            0: m_tready <= rst_n;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Holds the command on the bus until the transfer completes; tvalid stays
    // high so that back-to-back commands need no gap.
    task automatic send_command(logic cmd, key_t key);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= key;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic idle_cycles(int count);
        repeat (count) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata <= $urandom;
            s_tuser <= 1'($urandom);
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic key_t random_key();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sh00000000;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2: return key_t'(int'($urandom_range(0, 8)) - 4);
            default: return key_t'($urandom);
        endcase
    endfunction

    // Random gaps between bursts of back-to-back commands.
    task automatic send_paced(logic cmd, key_t key);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_command(cmd, key);
    endtask

    initial begin
        int            sent;
        int            seg_index;
        int            seg_len;
        int            insert_weight;
        segment_kind_t seg_kind;
        logic          cmd;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty extract, key extremes, duplicate keys, then drain past empty.
        send_command(CMD_EXTRACT, random_key());
        send_command(CMD_INSERT, 32'sh7FFFFFFF);
        send_command(CMD_INSERT, 32'sh80000000);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_INSERT, 32'sd1);
        send_command(CMD_INSERT, 32'sd5);
        send_command(CMD_INSERT, 32'sd5);
        send_command(CMD_INSERT, 32'sh80000000);
        send_command(CMD_INSERT, 32'sh7FFFFFFF);
        repeat (10) send_command(CMD_EXTRACT, key_t'($urandom));
        wait_drained();

        // Random: segments that push the heap full, drain it empty, or wander.
        sent = 0;
        seg_index = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg_index == 0)
                seg_kind = SEG_FILL;
            else if (seg_index == 1)
                seg_kind = SEG_DRAIN;
            else
                seg_kind = segment_kind_t'($urandom_range(0, 2));
            case (seg_kind)
                SEG_FILL: begin
                    insert_weight = 95;
                    seg_len = $urandom_range(150, 220);
                end
                SEG_DRAIN: begin
                    insert_weight = 8;
                    seg_len = $urandom_range(150, 220);
                end
                default: begin
                    insert_weight = 50;
                    seg_len = $urandom_range(50, 150);
                end
            endcase
            repeat (seg_len) begin
                cmd = ($urandom_range(0, 99) < insert_weight) ? CMD_INSERT : CMD_EXTRACT;
                send_paced(cmd, random_key());
                sent++;
            end
            if (seg_index % 3 == 1)
                wait_drained();
            seg_index++;
        end

        wait_drained();
        idle_cycles(40);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/bmh_pkg.sv
src/bmh_ram.sv
src/binary_max_heap_priority_queue.sv
bench/heap_result_checker.sv
bench/binary_max_heap_priority_queue_tb.sv
